>>> rtl/i2c_master_byte_engine_unit_defines.svh
`ifndef I2C_MASTER_BYTE_ENGINE_UNIT_DEFINES_SVH
`define I2C_MASTER_BYTE_ENGINE_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define I2CMBE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define I2CMBE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/i2cmbe_pkg.sv
package i2cmbe_pkg;

    localparam int TICK_W = 16;
    localparam int CMP_W  = (TICK_W > 16) ? TICK_W : 16;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_PHASE_TICKS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACK_POLL_LIMIT = 2'd1;

    localparam logic [15:0] PHASE_TICKS_RST    = 16'd2;
    localparam logic [7:0]  ACK_POLL_LIMIT_RST = 8'd250;

    localparam logic [2:0] CMD_NONE  = 3'd0;
    localparam logic [2:0] CMD_START = 3'd1;
    localparam logic [2:0] CMD_STOP  = 3'd2;
    localparam logic [2:0] CMD_WRITE = 3'd3;
    localparam logic [2:0] CMD_READ  = 3'd4;

    localparam logic [5:0] WR_ACK_LOW = 6'd24;
    localparam logic [5:0] WR_ACK_HI  = 6'd25;
    localparam logic [5:0] WR_POLL    = 6'd26;
    localparam logic [5:0] WR_STOP0   = 6'd27;
    localparam logic [5:0] WR_STOP1   = 6'd28;
    localparam logic [5:0] WR_END     = 6'd30;
    localparam logic [5:0] RD_ACK0    = 6'd16;
    localparam logic [5:0] RD_END     = 6'd18;
    localparam logic [5:0] START_END  = 6'd2;
    localparam logic [5:0] STOP_END   = 6'd3;

    typedef enum logic [4:0] {
        OP_IDLE  = 5'b00001,
        OP_START = 5'b00010,
        OP_STOP  = 5'b00100,
        OP_WRITE = 5'b01000,
        OP_READ  = 5'b10000
    } t_op;

    typedef struct packed {
        logic scl;
        logic sda;
        logic drv;
    } t_pins;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_drive;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       acked;
        logic       ack_timeout;
    } t_result;

endpackage

>>> rtl/i2cmbe_core.sv
module i2cmbe_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_adv,
    input  logic [2:0]           i_command,
    input  logic [7:0]           i_tx_byte,
    input  logic                 i_send_ack,
    input  logic                 i_sda_in,
    input  logic [15:0]          i_phase_ticks,
    input  logic [7:0]           i_ack_poll_limit,
    output i2cmbe_pkg::t_result  o_res
);
    import i2cmbe_pkg::*;

    t_op               r_op, n_op;
    logic [5:0]        r_step, n_step;
    logic [1:0]        r_sub, n_sub;
    logic [TICK_W-1:0] r_tick, n_tick;
    logic [7:0]        r_shift, n_shift;
    logic [7:0]        r_poll, n_poll;
    logic              r_ack, n_ack;
    t_pins             r_pins, n_pins;
    logic [7:0]        r_rx, n_rx;
    logic              r_acked, n_acked;
    logic              r_tmo, n_tmo;
    logic              n_done;
    logic [15:0]       dur_m1;
    logic              tick_end;
    logic [5:0]        step_end;

    function automatic t_pins mk_pins(input logic scl, input logic sda, input logic drv);
        t_pins p;
        p.scl = scl;
        p.drv = drv;
        p.sda = drv ? sda : 1'b1;
        return p;
    endfunction

    function automatic t_pins stop_pins(input logic [1:0] k);
        t_pins p;
        case (k)
            2'd0:    p = mk_pins(1'b0, 1'b0, 1'b1);
            2'd1:    p = mk_pins(1'b1, 1'b0, 1'b1);
            default: p = mk_pins(1'b1, 1'b1, 1'b1);
        endcase
        return p;
    endfunction

    function automatic t_pins phase_pins(input t_op op, input logic [5:0] p,
                                         input logic [1:0] sub, input logic msb,
                                         input logic ack, input t_pins cur);
        t_pins q;
        q = cur;
        case (op)
            OP_START: q = mk_pins(1'b1, (p == 6'd0), 1'b1);
            OP_STOP:  q = stop_pins(p[1:0]);
            OP_WRITE: begin
                if (p < WR_ACK_LOW) begin
                    q = mk_pins((sub == 2'd1), msb, 1'b1);
                end else if (p == WR_ACK_LOW) begin
                    q = mk_pins(1'b0, 1'b1, 1'b0);
                end else if (p == WR_ACK_HI) begin
                    q = mk_pins(1'b1, 1'b1, 1'b0);
                end else if (p == WR_STOP0) begin
                    q = stop_pins(2'd0);
                end else if (p == WR_STOP1) begin
                    q = stop_pins(2'd1);
                end else if (p > WR_STOP1) begin
                    q = stop_pins(2'd2);
                end
            end
            OP_READ: begin
                if (p < RD_ACK0) begin
                    q = mk_pins(p[0], 1'b1, 1'b0);
                end else begin
                    q = mk_pins((p != RD_ACK0), ~ack, 1'b1);
                end
            end
            default: q = cur;
        endcase
        return q;
    endfunction

    assign dur_m1   = (i_phase_ticks == 16'd0) ? 16'd0 : i_phase_ticks - 16'd1;
    assign tick_end = (CMP_W'(r_tick) >= CMP_W'(dur_m1)) || (r_tick == '1);

    always_comb begin
        case (r_op)
            OP_START: step_end = START_END;
            OP_STOP:  step_end = STOP_END;
            OP_WRITE: step_end = WR_END;
            default:  step_end = RD_END;
        endcase
    end

    always_comb begin
        n_op    = r_op;
        n_step  = r_step;
        n_sub   = r_sub;
        n_tick  = r_tick;
        n_shift = r_shift;
        n_poll  = r_poll;
        n_ack   = r_ack;
        n_pins  = r_pins;
        n_rx    = r_rx;
        n_acked = r_acked;
        n_tmo   = r_tmo;
        n_done  = 1'b0;
        if (r_op == OP_IDLE) begin
            if (i_command inside {[CMD_START:CMD_READ]}) begin
                case (i_command)
                    CMD_START: n_op = OP_START;
                    CMD_STOP:  n_op = OP_STOP;
                    CMD_WRITE: n_op = OP_WRITE;
                    default:   n_op = OP_READ;
                endcase
                n_step  = '0;
                n_sub   = '0;
                n_tick  = '0;
                n_poll  = '0;
                n_shift = (i_command == CMD_WRITE) ? i_tx_byte : 8'd0;
                n_ack   = i_send_ack;
                n_pins  = phase_pins(n_op, 6'd0, 2'd0, n_shift[7], i_send_ack, r_pins);
            end
        end else if (r_op == OP_WRITE && r_step == WR_POLL) begin
            if (!i_sda_in) begin
                n_pins  = mk_pins(1'b0, 1'b1, 1'b0);
                n_acked = 1'b1;
                n_tmo   = 1'b0;
                n_op    = OP_IDLE;
                n_step  = '0;
                n_tick  = '0;
                n_done  = 1'b1;
            end else if (r_poll >= i_ack_poll_limit) begin
                n_step = WR_STOP0;
                n_tick = '0;
                n_pins = stop_pins(2'd0);
            end else begin
                n_poll = r_poll + 8'd1;
            end
        end else if (tick_end) begin
            n_tick = '0;
            if (r_op == OP_WRITE && r_step < WR_ACK_LOW && r_sub == 2'd2) begin
                n_shift = {r_shift[6:0], 1'b0};
            end else if (r_op == OP_READ && r_step < RD_ACK0 && r_step[0]) begin
                n_shift = {r_shift[6:0], i_sda_in};
            end
            n_sub  = (r_sub == 2'd2) ? 2'd0 : r_sub + 2'd1;
            n_step = r_step + 6'd1;
            if (n_step >= step_end) begin
                case (r_op)
                    OP_START: n_pins = mk_pins(1'b0, 1'b0, 1'b1);
                    OP_WRITE: begin
                        n_acked = 1'b0;
                        n_tmo   = 1'b1;
                    end
                    OP_READ: begin
                        n_pins = mk_pins(1'b0, r_pins.sda, 1'b1);
                        n_rx   = n_shift;
                    end
                    default: n_pins = r_pins;
                endcase
                n_op   = OP_IDLE;
                n_step = '0;
                n_done = 1'b1;
            end else begin
                n_pins = phase_pins(r_op, n_step, n_sub, n_shift[7], r_ack, r_pins);
            end
        end else begin
            n_tick = r_tick + TICK_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op    <= OP_IDLE;
            r_step  <= '0;
            r_sub   <= '0;
            r_tick  <= '0;
            r_shift <= '0;
            r_poll  <= '0;
            r_ack   <= 1'b0;
            r_pins  <= mk_pins(1'b1, 1'b1, 1'b1);
            r_rx    <= '0;
            r_acked <= 1'b0;
            r_tmo   <= 1'b0;
        end else if (i_adv) begin
            r_op    <= n_op;
            r_step  <= n_step;
            r_sub   <= n_sub;
            r_tick  <= n_tick;
            r_shift <= n_shift;
            r_poll  <= n_poll;
            r_ack   <= n_ack;
            r_pins  <= n_pins;
            r_rx    <= n_rx;
            r_acked <= n_acked;
            r_tmo   <= n_tmo;
        end
    end

    always_comb begin
        o_res.scl_level   = n_pins.scl;
        o_res.sda_level   = n_pins.sda;
        o_res.sda_drive   = n_pins.drv;
        o_res.busy_res    = (n_op != OP_IDLE);
        o_res.done_res    = n_done;
        o_res.rx_byte     = n_rx;
        o_res.acked       = n_acked;
        o_res.ack_timeout = n_tmo;
    end

endmodule

>>> rtl/i2c_master_byte_engine_unit.sv
// Channel   Direction  Handshake                       Beat
// in        to block   i_in_valid / o_in_stall         command, tx_byte, send_ack, sda_in
// out       from block o_out_valid / i_out_stall       pins, busy, done, rx_byte, flags
// cfg       to block   i_cfg_valid / o_cfg_ready       register index, write data
//
// One input beat is one bus tick and yields one output beat; one beat per cycle sustained
// while o_in_stall is low. Engine state and tick counter update from the accepted beat, and
// the result lands in the output register (or skid, if stalled) on the same edge.
// A two-entry output (register plus skid) keeps input flowing while output is stalled;
// o_in_stall rises only when both entries hold results.
// Reset is synchronous, active low; the configuration port is always ready.
module i2c_master_byte_engine_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [2:0]                         i_command,
    input  logic [7:0]                         i_tx_byte,
    input  logic                               i_send_ack,
    input  logic                               i_sda_in,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic                               o_scl_level,
    output logic                               o_sda_level,
    output logic                               o_sda_drive,
    output logic                               o_busy_res,
    output logic                               o_done_res,
    output logic [7:0]                         o_rx_byte,
    output logic                               o_acked,
    output logic                               o_ack_timeout,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [i2cmbe_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [i2cmbe_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import i2cmbe_pkg::*;

    logic [15:0] r_phase_ticks;
    logic [7:0]  r_ack_poll_limit;
    t_result     res;
    t_result     r_out;
    t_result     r_skid;
    logic        r_out_valid;
    logic        r_skid_valid;
    logic        accept;
    logic        take;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_skid_valid;
    assign accept      = i_in_valid && !r_skid_valid;
    assign take        = r_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_ticks    <= PHASE_TICKS_RST;
            r_ack_poll_limit <= ACK_POLL_LIMIT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_PHASE_TICKS:    r_phase_ticks    <= i_cfg_data[15:0];
                REG_ACK_POLL_LIMIT: r_ack_poll_limit <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    i2cmbe_core u_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_adv            (accept),
        .i_command        (i_command),
        .i_tx_byte        (i_tx_byte),
        .i_send_ack       (i_send_ack),
        .i_sda_in         (i_sda_in),
        .i_phase_ticks    (r_phase_ticks),
        .i_ack_poll_limit (r_ack_poll_limit),
        .o_res            (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || take) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= accept;
            end
        end else if (accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || take) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (accept) begin
                r_out <= res;
            end
        end else if (accept) begin
            r_skid <= res;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_scl_level   = r_out.scl_level;
    assign o_sda_level   = r_out.sda_level;
    assign o_sda_drive   = r_out.sda_drive;
    assign o_busy_res    = r_out.busy_res;
    assign o_done_res    = r_out.done_res;
    assign o_rx_byte     = r_out.rx_byte;
    assign o_acked       = r_out.acked;
    assign o_ack_timeout = r_out.ack_timeout;

endmodule

>>> rtl/i2cmbe_checker.sv
`include "i2c_master_byte_engine_unit_defines.svh"

module i2cmbe_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_in_valid,
    input logic                               o_in_stall,
    input logic                               o_out_valid,
    input logic                               i_out_stall,
    input logic                               o_scl_level,
    input logic                               o_sda_level,
    input logic                               o_sda_drive,
    input logic                               o_busy_res,
    input logic                               o_done_res,
    input logic [7:0]                         o_rx_byte,
    input logic                               o_acked,
    input logic                               o_ack_timeout
);

    `I2CMBE_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n,
        o_out_valid && i_out_stall,
        o_out_valid && $stable(o_rx_byte) && $stable(o_scl_level) && $stable(o_busy_res),
        "stalled output beat changed")

    `I2CMBE_ASSERT_NOW(a_done_idle, i_clk, i_rst_n,
        o_out_valid && o_done_res, !o_busy_res,
        "done reported while still busy")

    `I2CMBE_ASSERT_NOW(a_released_high, i_clk, i_rst_n,
        o_out_valid && !o_sda_drive, o_sda_level,
        "released SDA not reported high")

    `I2CMBE_ASSERT_NOW(a_stall_full, i_clk, i_rst_n,
        o_in_stall, o_out_valid,
        "input stalled with empty output register")

endmodule

bind i2c_master_byte_engine_unit i2cmbe_checker u_checker (.*);
